FILE: design/u8u2_pkg.sv
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u2_pkg;

  // Result status codes
  localparam logic [1:0] ST_UNIT     = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;
  localparam logic [1:0] ST_END_ONLY = 2'd3;

  // Continuation bytes still due
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // Byte-order mark bytes
  localparam logic [7:0] BOM_B0 = 8'hEF;
  localparam logic [7:0] BOM_B1 = 8'hBB;
  localparam logic [7:0] BOM_B2 = 8'hBF;

  // Lead byte classes (upper bits of the byte)
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;

  typedef struct packed {
    logic [15:0] partial;
    logic [1:0]  pending;
    logic        mark;
  } dec_state_t;

  typedef struct packed {
    logic        emit;
    logic [15:0] unit;
    logic [1:0]  status;
  } dec_result_t;

endpackage

`default_nettype wire

FILE: design/u8u2_step.sv
// ----------------------------------------------------------------------------
// u8u2_step
// Combinational decode of one byte against the current sequence state.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u2_step (
  input  wire u8u2_pkg::dec_state_t  state_i,
  input  wire logic [7:0]            byte_i,
  input  wire logic                  last_i,
  output u8u2_pkg::dec_state_t       state_o,
  output u8u2_pkg::dec_result_t      result_o
);

  always_comb begin
    state_o         = state_i;
    result_o.emit   = 1'b0;
    result_o.unit   = 16'h0000;
    result_o.status = u8u2_pkg::ST_UNIT;

    unique case (state_i.pending)
      u8u2_pkg::PEND_NONE: begin
        if (!byte_i[7]) begin
          result_o.unit = {8'h00, byte_i};
          result_o.emit = 1'b1;
        end else if (byte_i[7:5] == u8u2_pkg::LEAD2_TAG) begin
          state_o.partial = {5'b0, byte_i[4:0], 6'b0};
          state_o.pending = u8u2_pkg::PEND_ONE;
          state_o.mark    = 1'b0;
        end else if (byte_i[7:4] == u8u2_pkg::LEAD3_TAG) begin
          state_o.partial = {byte_i[3:0], 12'h000};
          state_o.pending = u8u2_pkg::PEND_TWO;
          state_o.mark    = (byte_i == u8u2_pkg::BOM_B0);
        end else begin
          // stray continuation or four-byte lead: flag and drop
          result_o.status = u8u2_pkg::ST_BAD_LEAD;
          result_o.emit   = 1'b1;
        end
      end
      u8u2_pkg::PEND_ONE: begin
        state_o = '0;
        if (state_i.mark && (byte_i == u8u2_pkg::BOM_B2)) begin
          // complete mark: drop, unless it ends the string
          if (last_i) begin
            result_o.status = u8u2_pkg::ST_END_ONLY;
            result_o.emit   = 1'b1;
          end
        end else begin
          result_o.unit = state_i.partial | {10'b0, byte_i[5:0]};
          result_o.emit = 1'b1;
        end
      end
      default: begin
        // two due (a count of three behaves the same)
        state_o.partial = state_i.partial | {4'b0, byte_i[5:0], 6'b0};
        state_o.pending = u8u2_pkg::PEND_ONE;
        state_o.mark    = state_i.mark && (byte_i == u8u2_pkg::BOM_B1);
      end
    endcase

    if (last_i) begin
      if (!result_o.emit) begin
        result_o.unit   = 16'h0000;
        result_o.status = u8u2_pkg::ST_TRUNC;
        result_o.emit   = 1'b1;
      end
      state_o = '0;
    end
  end

endmodule

`default_nettype wire

FILE: design/utf8_to_ucs2_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_core
// Streaming UTF-8 to UCS-2 decoder: one byte in, at most one code unit out.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o | byte_in_i, end_of_string_i
//  out     | output    | out_valid_o / out_stall_i | code_unit_o, status_o,
//          |           |                        | last_result_o
//
//  One byte per cycle sustained while the output is not stalled. A byte lands
//  in the input register, is decoded against the sequence state in the next
//  cycle and its result (if any) lands in the output register, from which it
//  is offered on the out channel.
//  Reset clears the valid flags and the sequence state; payload is unreset.
//  While the output beat is stalled the input register still takes one beat;
//  a byte that gives no result passes through even while the output waits.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_decoder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        end_of_string_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      code_unit_o,
  output logic [1:0]       status_o,
  output logic             last_result_o
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Sequence state
  u8u2_pkg::dec_state_t state_q, state_d;
  u8u2_pkg::dec_result_t step_res;

  // Output register
  logic        out_valid_q;
  logic [15:0] out_unit_q;
  logic [1:0]  out_status_q;
  logic        out_last_q;

  logic out_free;
  logic advance;
  logic in_take;

  u8u2_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // Output slot can take a result when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;
  // Advance the held byte unless its result has nowhere to go
  assign advance  = in_valid_q && (out_free || !step_res.emit);
  // Hold the input while the held byte cannot move on
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && step_res.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_in_i;
      in_last_q <= end_of_string_i;
    end
    if (advance && step_res.emit) begin
      out_unit_q   <= step_res.unit;
      out_status_q <= step_res.status;
      out_last_q   <= in_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_unit_o   = out_unit_q;
  assign status_o      = out_status_q;
  assign last_result_o = out_last_q;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to UCS-2 decoder core. A scoreboard
// decodes every accepted input beat itself and queues the code unit that
// should come out. Each output beat is compared field by field with the
// oldest queued unit. The stimulus starts with five short directed strings and
// then sends random, mostly well-formed UTF-8 strings, with bursty input,
// a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int CLK_HALF     = 4;     // 8 ns period
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_BEATS = 750;   // stop launching strings past this
  localparam int HOLD_AT_BEAT = 300;   // start the long output hold-off here
  localparam int HOLD_CYCLES  = 160;
  localparam int DRAIN_CYCLES = 8;     // extra wait once the queue is empty, for strays
  localparam int IDLE_LIMIT   = 2000;  // cycles without any beat before giving up

  typedef logic [7:0] byte_q_t [$];

  // One expected output beat
  typedef struct packed {
    logic [15:0] unit;
    logic [1:0]  status;
    logic        last;
  } unit_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the sequence state, decodes each
  // accepted byte and checks output beats against the queue in order.
  // --------------------------------------------------------------------------
  class ucs2_scoreboard;
    logic [15:0] acc_value;   // code value built up so far
    logic [1:0]  cont_due;    // continuation bytes still to come
    logic        bom_seen;    // pending 3-byte sequence still looks like a BOM
    unit_beat_t  expected_units [$];
    int          errors;

    function new();
      acc_value = '0;
      cont_due  = u8u2_pkg::PEND_NONE;
      bom_seen  = 1'b0;
      errors    = 0;
    endfunction

    function void clear_seq();
      acc_value = '0;
      cont_due  = u8u2_pkg::PEND_NONE;
      bom_seen  = 1'b0;
    endfunction

    // Decode one byte; 'emits' tells whether it yields an output beat.
    function void decode_byte(input logic [7:0] b, input logic eos,
                              output unit_beat_t res, output logic emits);
      logic strip;
      res.unit   = '0;
      res.status = u8u2_pkg::ST_UNIT;
      res.last   = eos;
      emits      = 1'b0;
      strip      = 1'b0;
      case (cont_due)
        u8u2_pkg::PEND_NONE: begin
          if (!b[7]) begin
            // plain ASCII, zero included, goes straight out
            res.unit = {8'h00, b};
            emits    = 1'b1;
          end else if (b[7:5] == u8u2_pkg::LEAD2_TAG) begin
            acc_value = {5'b0, b[4:0], 6'b0};
            cont_due  = u8u2_pkg::PEND_ONE;
            bom_seen  = 1'b0;
          end else if (b[7:4] == u8u2_pkg::LEAD3_TAG) begin
            acc_value = {b[3:0], 12'h000};
            cont_due  = u8u2_pkg::PEND_TWO;
            bom_seen  = (b == u8u2_pkg::BOM_B0);
          end else begin
            // stray continuation or four-byte lead: flag and drop
            res.status = u8u2_pkg::ST_BAD_LEAD;
            emits      = 1'b1;
          end
        end
        u8u2_pkg::PEND_ONE: begin
          strip = bom_seen && (b == u8u2_pkg::BOM_B2);
          if (strip) begin
            // a whole mark is swallowed unless it ends the string
            if (eos) begin
              res.status = u8u2_pkg::ST_END_ONLY;
              emits      = 1'b1;
            end
          end else begin
            res.unit = acc_value | {10'b0, b[5:0]};
            emits    = 1'b1;
          end
          clear_seq();
        end
        default: begin
          // middle byte of a 3-byte sequence (a count of three acts as two)
          acc_value = acc_value | {4'b0, b[5:0], 6'b0};
          cont_due  = u8u2_pkg::PEND_ONE;
          bom_seen  = bom_seen && (b == u8u2_pkg::BOM_B1);
        end
      endcase
      if (eos) begin
        if (!emits) begin
          res.unit   = '0;
          res.status = u8u2_pkg::ST_TRUNC;
          emits      = 1'b1;
        end
        clear_seq();
      end
    endfunction

    function void note_byte(input logic [7:0] b, input logic eos);
      unit_beat_t res;
      logic       emits;
      decode_byte(b, eos, res, emits);
      if (emits) expected_units.push_back(res);
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_unit(input logic [15:0] unit, input logic [1:0] status,
                    input logic last);
      unit_beat_t exp_beat;
      if (expected_units.size() == 0) begin
        report($sformatf("unexpected beat unit=%h status=%0d last=%b",
                         unit, status, last));
      end else begin
        exp_beat = expected_units.pop_front();
        if (unit !== exp_beat.unit)
          report($sformatf("code_unit %h, want %h", unit, exp_beat.unit));
        if (status !== exp_beat.status)
          report($sformatf("status %0d, want %0d", status, exp_beat.status));
        if (last !== exp_beat.last)
          report($sformatf("last_result %b, want %b", last, exp_beat.last));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports
  // --------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_r = 1'b0;
  logic [7:0]  byte_r = 8'h00;
  logic        eos_r = 1'b0;
  logic        out_stall_r = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [15:0] code_unit_o;
  logic [1:0]  status_o;
  logic        last_result_o;

  ucs2_scoreboard sb = new();
  int beats_in   = 0;
  int burst_left = 0;

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  utf8_to_ucs2_decoder_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_r),
    .in_stall_o      (in_stall_o),
    .byte_in_i       (byte_r),
    .end_of_string_i (eos_r),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_r),
    .code_unit_o     (code_unit_o),
    .status_o        (status_o),
    .last_result_o   (last_result_o)
  );

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one byte and hold it until the block takes it. Valid stays high
  // into the next beat while a burst lasts; between bursts drop it for a
  // random gap.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    in_valid_r <= 1'b1;
    byte_r     <= b;
    eos_r      <= eos;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, eos);
    beats_in++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_valid_r <= 1'b0;
      repeat (gap) @(posedge clk_i);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 15);
    end
  endtask

  // Send a string; the final byte carries the end flag.
  task automatic send_string(input byte_q_t str);
    for (int i = 0; i < str.size(); i++)
      send_byte(str[i], i == str.size() - 1);
  endtask

  // Continuation byte: mostly well formed, sometimes any byte at all since
  // the block only takes its low six bits.
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Build one random string: ASCII, 2- and 3-byte characters, marks,
  // noise, and now and then an ending that cuts a sequence short.
  function automatic byte_q_t random_string();
    byte_q_t str;
    int      n_chars;
    int      pick;
    logic [7:0] noise;
    str     = {};
    n_chars = $urandom_range(1, 10);
    for (int c = 0; c < n_chars; c++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        str.push_back(8'($urandom_range(0, 127)));
      end else if (pick < 60) begin
        str.push_back(8'hC0 | 8'($urandom_range(0, 31)));
        str.push_back(cont_byte());
      end else if (pick < 85) begin
        str.push_back(8'hE0 | 8'($urandom_range(0, 15)));
        str.push_back(cont_byte());
        str.push_back(cont_byte());
      end else if (pick < 90) begin
        str.push_back(u8u2_pkg::BOM_B0);
        str.push_back(u8u2_pkg::BOM_B1);
        str.push_back(u8u2_pkg::BOM_B2);
      end else if (pick < 93) begin
        // mark that breaks off on its second or third byte
        str.push_back(u8u2_pkg::BOM_B0);
        if ($urandom_range(0, 1)) begin
          str.push_back(u8u2_pkg::BOM_B1);
          str.push_back(cont_byte());
        end else begin
          str.push_back(cont_byte());
          str.push_back(u8u2_pkg::BOM_B2);
        end
      end else begin
        noise = $urandom_range(0, 1) ? (8'h80 | 8'($urandom_range(0, 63)))
                                     : (8'hF0 | 8'($urandom_range(0, 15)));
        str.push_back(noise);
      end
    end
    // cut the tail short: a bare lead, a 3-byte lead with or without one more byte, or half a mark
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      str.push_back(8'hC0 | 8'($urandom_range(0, 31)));
    end else if (pick < 12) begin
      str.push_back(8'hE0 | 8'($urandom_range(0, 15)));
      if ($urandom_range(0, 1)) str.push_back(cont_byte());
    end else if (pick < 15) begin
      str.push_back(u8u2_pkg::BOM_B0);
      str.push_back(u8u2_pkg::BOM_B1);
    end
    return str;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    byte_q_t str;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ASCII extremes, 2- and 3-byte characters, a dropped mark,
    // a 3-byte sequence that only starts like a mark, bad leads, then
    // a string ending on a mark, two truncated strings and a lone zero.
    str = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC,
            8'hEF, 8'hBB, 8'hBF, 8'hEF, 8'hBF, 8'hBD, 8'h80, 8'hF0, 8'hFF};
    send_string(str);
    str = '{8'hEF, 8'hBB, 8'hBF};
    send_string(str);
    str = '{8'hC3};
    send_string(str);
    str = '{8'hE2, 8'h82};
    send_string(str);
    str = '{8'h00};
    send_string(str);

    // Random strings until enough beats have gone in
    while (beats_in < RANDOM_BEATS) begin
      str = random_string();
      send_string(str);
    end
    in_valid_r <= 1'b0;

    // Wait for every queued unit, then wait out DRAIN_CYCLES for strays
    while (sb.expected_units.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_units.size() != 0)
      sb.report($sformatf("%0d units never arrived", sb.expected_units.size()));
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side: stall in patterns of random length, and once hold off
  // for a long stretch so that the block fills up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : stall_pattern
    int   mode;
    int   span;
    int   hold_left;
    logic hold_done;
    logic nxt;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(posedge clk_i);
        if (!hold_done && beats_in >= HOLD_AT_BEAT) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
        if (hold_left > 0) begin
          nxt = 1'b1;
          hold_left--;
        end else begin
          case (mode)
            0:       nxt = 1'b0;                          // free flow
            1:       nxt = ($urandom_range(0, 3) == 0);   // light stall
            2:       nxt = ($urandom_range(0, 3) != 0);   // heavy stall
            default: nxt = ~out_stall_r;                  // alternating
          endcase
        end
        out_stall_r <= nxt;
      end
    end
  end

  // Check every output beat taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_r)
      sb.check_unit(code_unit_o, status_o, last_result_o);
  end

  // Give up when neither channel has moved a beat for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_r && !in_stall_o) || (out_valid_o && !out_stall_r))
        idle = 0;
      else
        idle++;
    end
    $display("FAIL");
    $finish;
  end

endmodule
